@@ rtl/core/tcch_pkg.sv @@
// Shared types, constants and elaboration-time table builders for the compass heading block.
package tcch_pkg;

  localparam int AXIS_W    = 17;   // raw axis minus hard-iron offset
  localparam int CFG_W     = 16;
  localparam int HEAD_W    = 9;
  localparam int SIN_W     = 21;   // quarter-wave entry, up to 2^20
  localparam int MAX_STEPS = 24;
  localparam int QUART     = 90;
  localparam int HALF      = 180;
  localparam int THREEQ    = 270;
  localparam int TURN      = 360;
  localparam int TURN2     = 720;
  localparam int TURN3     = 1080;
  localparam int DEG_SCALE = 18000;  // 180 deg times 100
  localparam int QB        = 10;     // quotient bits of the degree divide
  localparam int NUM_W     = 50;     // signed numerator of the degree divide
  localparam int ZW        = 34;     // Q30 angle accumulator

  localparam longint ANG_PI        = 64'd3373259426;
  localparam longint ANG_HALF_PI   = 64'd1686629713;
  localparam longint DIV_DEN       = 100 * ANG_PI;
  localparam longint DEG_HALF_TURN = 64'd180;

  localparam logic [1:0] CFG_HARD_IRON_X = 2'd0;
  localparam logic [1:0] CFG_HARD_IRON_Y = 2'd1;
  localparam logic [1:0] CFG_HARD_IRON_Z = 2'd2;
  localparam logic [1:0] CFG_BIAS        = 2'd3;

  typedef struct packed {
    logic signed [CFG_W-1:0] x;
    logic signed [CFG_W-1:0] y;
    logic signed [CFG_W-1:0] z;
  } hard_iron_t;

  typedef logic [90:0][SIN_W-1:0]      sin_tab_t;
  typedef logic [MAX_STEPS-1:0][30:0]  atan_tab_t;

  // shift-subtract divide, only used while building elaboration-time constants (tables and the divide reciprocal)
  function automatic longint unsigned udiv(input longint unsigned n, input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(r deg) in Q30, r in 0..90, truncated Taylor series
  function automatic longint unsigned sin_q30(input int r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint s;
    int n;
    x = (longint'(r) * ANG_PI + 64'd90) / DEG_HALF_TURN;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    n = 1;
    while (n <= 20 && t != 0) begin
      t = udiv((t * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
      n++;
    end
    return longint'(s);
  endfunction

  function automatic sin_tab_t build_sin_tab(input int f);
    sin_tab_t tab;
    longint unsigned v;
    for (int r = 0; r <= QUART; r++) begin
      v = sin_q30(r);
      tab[r] = SIN_W'((v + (64'd1 << (29 - f))) >> (30 - f));
    end
    return tab;
  endfunction

  // atan(2^-i) in Q30, arctan series
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    longint unsigned s;
    longint unsigned term;
    int sh;
    tab[0] = 31'((ANG_PI + 2) >> 2);
    for (int i = 1; i < MAX_STEPS; i++) begin
      s = '0;
      for (int n = 0; n < 64; n++) begin
        sh = i * (2 * n + 1);
        if (sh < 60) begin
          term = udiv(64'd1 << (60 - sh), longint'(2 * n + 1));
          if (n % 2 == 1) s = s - term;
          else s = s + term;
        end
      end
      tab[i] = 31'((s + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

endpackage

@@ rtl/core/tilt_compensated_compass_heading_top.sv @@
// Top level of the tilt-compensated compass heading block.
// One magnetometer word (x, y, z plus whole-degree pitch and roll) goes in,
// one heading in whole degrees (0..359) comes out, in order. The block takes
// a new word every clock cycle as long as the result side keeps popping.
// From push to the out_ ports a word passes one front register (offset
// removal and sin/cos lookup), a four-word queue, five projection stages,
// one CORDIC stage per iteration, two stages for the bias add, four stages
// of a reciprocal multiply divide by 100*pi with a remainder correction, and
// a two-word result queue. The back pipeline advances as one unit and stops
// only while its last stage holds a word the result queue cannot take; the
// front keeps filling the middle queue meanwhile. Configuration registers:
// 0..2 hard-iron x/y/z offsets, 3 heading bias in hundredths of a degree;
// write them only while idle.
module tilt_compensated_compass_heading_top #(
  parameter int CORDIC_STEPS   = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word
  input  logic                        push,
  output logic                        full,
  input  logic signed [15:0]          in_raw_x,
  input  logic signed [15:0]          in_raw_y,
  input  logic signed [15:0]          in_raw_z,
  input  logic signed [7:0]           in_pitch_deg,
  input  logic signed [7:0]           in_roll_deg,
  // result word
  output logic                        empty,
  input  logic                        pop,
  output logic [tcch_pkg::HEAD_W-1:0] out_heading_deg,
  // configuration
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tcch_pkg::CFG_W-1:0]  cfg_wdata
);
  import tcch_pkg::*;

  localparam int QW = 3 * AXIS_W + 4 * (TRIG_FRAC_BITS + 2);

  hard_iron_t       hi_r;
  logic [CFG_W-1:0] bias_r;

  logic          fq_push, fq_full, fq_empty, b_take;
  logic [QW-1:0] fq_din, fq_dout;
  logic          r_vld, oq_full;
  logic [HEAD_W-1:0] r_heading;

  // config registers, reset to the factory calibration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r.x <= 16'sd419;
      hi_r.y <= 16'sd395;
      hi_r.z <= -16'sd169;
      bias_r <= 16'd21465;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HARD_IRON_X: hi_r.x <= $signed(cfg_wdata);
        CFG_HARD_IRON_Y: hi_r.y <= $signed(cfg_wdata);
        CFG_HARD_IRON_Z: hi_r.z <= $signed(cfg_wdata);
        CFG_BIAS:        bias_r <= cfg_wdata;
        default:         bias_r <= bias_r;
      endcase
    end
  end

  tcch_front #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .raw_x     (in_raw_x),
    .raw_y     (in_raw_y),
    .raw_z     (in_raw_z),
    .pitch_deg (in_pitch_deg),
    .roll_deg  (in_roll_deg),
    .hard_iron (hi_r),
    .q_push    (fq_push),
    .q_data    (fq_din),
    .q_full    (fq_full)
  );

  // decouples the front from back-end stalls
  tcch_queue #(.WIDTH(QW), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_din),
    .pop   (b_take),
    .dout  (fq_dout),
    .full  (fq_full),
    .empty (fq_empty)
  );

  tcch_back #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (!fq_empty),
    .in_data     (fq_dout),
    .take        (b_take),
    .bias        (bias_r),
    .res_room    (!oq_full),
    .res_vld     (r_vld),
    .res_heading (r_heading)
  );

  // result skid: holds finished headings while the consumer stalls
  tcch_queue #(.WIDTH(HEAD_W), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_vld),
    .din   (r_heading),
    .pop   (pop),
    .dout  (out_heading_deg),
    .full  (oq_full),
    .empty (empty)
  );
endmodule

@@ rtl/core/tcch_queue.sv @@
// Small register FIFO used between the front and back and on the result side.
module tcch_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= din;
  end
endmodule

@@ rtl/core/tcch_front.sv @@
// Front end: takes a sample, removes hard-iron offsets, looks up sin/cos of pitch and roll.
module tcch_front #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic signed [15:0]          raw_x,
  input  logic signed [15:0]          raw_y,
  input  logic signed [15:0]          raw_z,
  input  logic signed [7:0]           pitch_deg,
  input  logic signed [7:0]           roll_deg,
  input  tcch_pkg::hard_iron_t        hard_iron,
  output logic                        q_push,
  output logic [3*tcch_pkg::AXIS_W+4*(TRIG_FRAC_BITS+2)-1:0] q_data,
  input  logic                        q_full
);
  import tcch_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam sin_tab_t SIN_TAB = build_sin_tab(TRIG_FRAC_BITS);

  logic                     f_vld_r, f_vld_nxt, load;
  logic signed [AXIS_W-1:0] dx_r, dy_r, dz_r;
  logic [8:0]               ap_r, ar_r;
  logic signed [TW-1:0]     sp, cp, sr, cr;

  // sin of a whole-degree angle in 0..359 from the quarter-wave table
  function automatic logic signed [TW-1:0] trig(input logic [8:0] a);
    logic [6:0]           r;
    logic                 mirror, negate;
    logic [SIN_W-1:0]     v;
    logic signed [TW-1:0] t;
    mirror = 1'b0;
    negate = 1'b0;
    if (a >= 9'(THREEQ)) begin
      r = 7'(a - 9'(THREEQ)); mirror = 1'b1; negate = 1'b1;
    end else if (a >= 9'(HALF)) begin
      r = 7'(a - 9'(HALF)); negate = 1'b1;
    end else if (a >= 9'(QUART)) begin
      r = 7'(a - 9'(QUART)); mirror = 1'b1;
    end else begin
      r = 7'(a);
    end
    v = mirror ? SIN_TAB[7'(QUART) - r] : SIN_TAB[r];
    t = $signed(TW'(v));
    return negate ? -t : t;
  endfunction

  function automatic logic [8:0] cos_arg(input logic [8:0] a);
    logic [9:0] s;
    s = 10'(a) + 10'(QUART);
    return (s >= 10'(TURN)) ? 9'(s - 10'(TURN)) : 9'(s);
  endfunction

  function automatic logic [8:0] wrap_deg(input logic signed [7:0] d);
    return d[7] ? 9'(10'($signed(d)) + 10'(TURN)) : 9'(d);
  endfunction

  assign full   = f_vld_r && q_full;
  assign load   = push && !full;
  assign q_push = f_vld_r;

  assign sp = trig(ap_r);
  assign cp = trig(cos_arg(ap_r));
  assign sr = trig(ar_r);
  assign cr = trig(cos_arg(ar_r));
  assign q_data = {dx_r, dy_r, dz_r, sp, cp, sr, cr};

  always_comb begin
    if (load) f_vld_nxt = 1'b1;
    else if (!q_full) f_vld_nxt = 1'b0;
    else f_vld_nxt = f_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= AXIS_W'(raw_x) - AXIS_W'(hard_iron.x);
      dy_r <= AXIS_W'(raw_y) - AXIS_W'(hard_iron.y);
      dz_r <= AXIS_W'(raw_z) - AXIS_W'(hard_iron.z);
      ap_r <= wrap_deg(pitch_deg);
      ar_r <= wrap_deg(roll_deg);
    end
  end
endmodule

@@ rtl/core/tcch_back.sv @@
// Back end: tilt projection, CORDIC vectoring, bias add, degree divide and wrap.
module tcch_back #(
  parameter int CORDIC_STEPS   = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [3*tcch_pkg::AXIS_W+4*(TRIG_FRAC_BITS+2)-1:0] in_data,
  output logic                        take,
  input  logic [tcch_pkg::CFG_W-1:0]  bias,
  input  logic                        res_room,
  output logic                        res_vld,
  output logic [tcch_pkg::HEAD_W-1:0] res_heading
);
  import tcch_pkg::*;

  localparam int F   = TRIG_FRAC_BITS;
  localparam int N   = CORDIC_STEPS;
  localparam int TW  = F + 2;
  localparam int PW  = F + 19;
  localparam int TDW = F + 20;
  localparam int XW  = 2 * F + 22;
  localparam int HW  = F + 22;
  localparam int CW  = F + 23;
  localparam int MW  = NUM_W - 1;
  localparam int DS  = 4;          // divide stages after the magnitude stage
  localparam int RW  = 25;         // numerator top bits and reciprocal width
  localparam int PRW = 2 * RW;
  localparam int NSH = MW - RW;    // numerator bits dropped before the multiply
  localparam int RSH = 63 - NSH;   // product shift, reciprocal is 2^63 / den
  localparam longint unsigned RECIP = udiv(64'h8000_0000_0000_0000, DIV_DEN);
  localparam logic [RW-1:0]   RECIP_W = RW'(RECIP);
  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  logic signed [AXIS_W-1:0] dx, dy, dz;
  logic signed [TW-1:0]     sp, cp, sr, cr;
  logic                     adv;

  // projection stages
  logic [3:0]            sv_r;
  logic signed [PW-1:0]  m_dxcp_r, m_dysr_r, m_dzcr_r, m_dycr_r, m_dzsr_r;
  logic signed [TW-1:0]  sp0_r, sp1_r;
  logic signed [TDW-1:0] t_r;
  logic signed [HW-1:0]  yh1_r, yh2_r, yh3_r, xh_r;
  logic signed [PW-1:0]  dxcp1_r, dxcp2_r;
  logic signed [XW-1:0]  tsp_r;

  // CORDIC stages, index 0 holds the pre-rotated vector
  logic                  cv_r [N+1];
  logic                  ck_r [N+1];
  logic signed [CW-1:0]  cx_r [N+1];
  logic signed [CW-1:0]  cy_r [N+1];
  logic signed [ZW-1:0]  cz_r [N+1];
  logic signed [CW-1:0]  cx_nxt [N];
  logic signed [CW-1:0]  cy_nxt [N];
  logic signed [ZW-1:0]  cz_nxt [N];
  logic signed [CW-1:0]  x0_nxt, y0_nxt;
  logic signed [ZW-1:0]  z0_nxt;

  // angle to degrees
  logic                    s5_v_r;
  logic signed [NUM_W-1:0] mz_r, mb_r, num;
  logic signed [ZW-1:0]    z_fin;
  logic                    dv_r [DS+1];
  logic                    dn_r [DS+1];
  logic [MW-1:0]           dabs_r, dn1_r, dn2_r, drem_r;
  logic [PRW-1:0]          dprod_r;
  logic [QB-1:0]           dqe_r, dq3_r, dq_r;
  logic [10:0]             hv;

  assign {dx, dy, dz, sp, cp, sr, cr} = in_data;

  assign adv     = !dv_r[DS] || res_room;
  assign take    = adv && in_vld;
  assign res_vld = adv && dv_r[DS];

  // quadrant pre-rotation puts x on the right half plane
  always_comb begin
    x0_nxt = CW'(xh_r);
    y0_nxt = -CW'(yh3_r);
    z0_nxt = '0;
    if (x0_nxt < 0) begin
      if (y0_nxt >= 0) begin
        x0_nxt = -CW'(yh3_r);
        y0_nxt = -CW'(xh_r);
        z0_nxt = ZW'(ANG_HALF_PI);
      end else begin
        x0_nxt = CW'(yh3_r);
        y0_nxt = CW'(xh_r);
        z0_nxt = -ZW'(ANG_HALF_PI);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (!cy_r[k][CW-1]) begin
        cx_nxt[k] = cx_r[k] + (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] - (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] + $signed(ZW'(ATAN_TAB[k]));
      end else begin
        cx_nxt[k] = cx_r[k] - (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] + (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] - $signed(ZW'(ATAN_TAB[k]));
      end
    end
  end

  assign z_fin = ck_r[N] ? '0 : cz_r[N];
  assign num   = mz_r + mb_r;

  // heading = (1080 - deg) mod 360, deg truncated toward zero
  always_comb begin
    hv = dn_r[DS] ? 11'(TURN3) + 11'(dq_r) : 11'(TURN3) - 11'(dq_r);
    priority if (hv >= 11'(TURN3)) res_heading = HEAD_W'(hv - 11'(TURN3));
    else if (hv >= 11'(TURN2))     res_heading = HEAD_W'(hv - 11'(TURN2));
    else if (hv >= 11'(TURN))      res_heading = HEAD_W'(hv - 11'(TURN));
    else                           res_heading = HEAD_W'(hv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r   <= '0;
      s5_v_r <= 1'b0;
      for (int k = 0; k <= N; k++) cv_r[k] <= 1'b0;
      for (int j = 0; j <= DS; j++) dv_r[j] <= 1'b0;
    end else if (adv) begin
      sv_r   <= {sv_r[2:0], in_vld};
      cv_r[0] <= sv_r[3];
      for (int k = 0; k < N; k++) cv_r[k+1] <= cv_r[k];
      s5_v_r <= cv_r[N];
      dv_r[0] <= s5_v_r;
      for (int j = 0; j < DS; j++) dv_r[j+1] <= dv_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_dxcp_r <= PW'(dx) * PW'(cp);
      m_dysr_r <= PW'(dy) * PW'(sr);
      m_dzcr_r <= PW'(dz) * PW'(cr);
      m_dycr_r <= PW'(dy) * PW'(cr);
      m_dzsr_r <= PW'(dz) * PW'(sr);
      sp0_r    <= sp;

      t_r     <= TDW'(m_dysr_r) - TDW'(m_dzcr_r);
      yh1_r   <= HW'(m_dycr_r) + HW'(m_dzsr_r);
      dxcp1_r <= m_dxcp_r;
      sp1_r   <= sp0_r;

      tsp_r   <= XW'(t_r) * XW'(sp1_r);
      dxcp2_r <= dxcp1_r;
      yh2_r   <= yh1_r;

      xh_r  <= HW'(dxcp2_r) + HW'(tsp_r >>> F);
      yh3_r <= yh2_r;

      cx_r[0] <= x0_nxt;
      cy_r[0] <= y0_nxt;
      cz_r[0] <= z0_nxt;
      ck_r[0] <= (xh_r == '0) && (yh3_r == '0);
      for (int k = 0; k < N; k++) begin
        cx_r[k+1] <= cx_nxt[k];
        cy_r[k+1] <= cy_nxt[k];
        cz_r[k+1] <= cz_nxt[k];
        ck_r[k+1] <= ck_r[k];
      end

      mz_r <= NUM_W'(z_fin) * NUM_W'(DEG_SCALE);
      mb_r <= $signed(NUM_W'(bias)) * NUM_W'(ANG_PI);

      // divide |num| by 100*pi: reciprocal estimate is low by at most one,
      // the remainder compare fixes it; the sign is applied afterwards
      dn_r[0] <= num[NUM_W-1];
      dabs_r  <= MW'(num[NUM_W-1] ? -num : num);
      dprod_r <= PRW'(dabs_r[MW-1:NSH]) * PRW'(RECIP_W);
      dn1_r   <= dabs_r;
      dqe_r   <= dprod_r[RSH+QB-1:RSH];
      dn2_r   <= dn1_r;
      drem_r  <= dn2_r - MW'(dqe_r * DIV_DEN);
      dq3_r   <= dqe_r;
      dq_r    <= dq3_r + QB'(drem_r >= MW'(DIV_DEN));
      for (int j = 0; j < DS; j++) dn_r[j+1] <= dn_r[j];
    end
  end
endmodule

@@ tb/sv/tcch_heading_checker.sv @@
// Checker for the compass heading block: tracks config writes, predicts headings, compares.
module tcch_heading_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        full,
  input  logic signed [15:0]          in_raw_x,
  input  logic signed [15:0]          in_raw_y,
  input  logic signed [15:0]          in_raw_z,
  input  logic signed [7:0]           in_pitch_deg,
  input  logic signed [7:0]           in_roll_deg,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [tcch_pkg::HEAD_W-1:0] out_heading_deg,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tcch_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcch_pkg::*;

  localparam int     STEPS = 16;
  localparam int     FRAC  = 15;
  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  logic signed [15:0] off_x, off_y, off_z;
  logic [15:0]        bias_cdeg;
  longint unsigned    quarter_sin[0:90];   // sin(r deg), Q30
  longint             arctan_q30[0:STEPS-1];
  logic [HEAD_W-1:0]  heading_q[$];

  initial begin
    longint unsigned x, x2, t, s, term;
    longint ss;
    int n, sh;
    for (int r = 0; r <= 90; r++) begin
      x  = (longint'(r) * PI_Q30 + 90) / 180;
      x2 = (x * x) >> 30;
      t  = x;
      ss = longint'(x);
      n  = 1;
      while (n <= 20 && t != 0) begin
        t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) ss = ss - longint'(t);
        else ss = ss + longint'(t);
        n++;
      end
      quarter_sin[r] = longint'(ss);
    end
    arctan_q30[0] = (PI_Q30 + 2) >>> 2;
    for (int i = 1; i < STEPS; i++) begin
      s = 0;
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh < 60) begin
          term = (64'd1 << (60 - sh)) / longint'(2 * k + 1);
          if (k % 2 == 1) s = s - term;
          else s = s + term;
        end
      end
      arctan_q30[i] = longint'((s + (64'd1 << 29)) >> 30);
    end
  end

  // sin of a whole degree 0..359 at FRAC fraction bits
  function automatic longint sin_frac(int a);
    int q, r;
    longint unsigned v;
    longint t;
    q = a / 90;
    r = a % 90;
    v = (q % 2 == 1) ? quarter_sin[90 - r] : quarter_sin[r];
    t = longint'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    return (q >= 2) ? -t : t;
  endfunction

  function automatic logic [HEAD_W-1:0] heading_of(
    logic signed [15:0] rx, logic signed [15:0] ry, logic signed [15:0] rz,
    logic signed [7:0] pd, logic signed [7:0] rd);
    longint dx, dy, dz, sp, cp, sr, cr, t, xh, yh, x, y, z, ox, xs, ys, deg, h;
    int ap, ar;
    dx = longint'(rx) - longint'(off_x);
    dy = longint'(ry) - longint'(off_y);
    dz = longint'(rz) - longint'(off_z);
    ap = (int'(pd) + 360) % 360;
    ar = (int'(rd) + 360) % 360;
    sp = sin_frac(ap);
    cp = sin_frac((ap + 90) % 360);
    sr = sin_frac(ar);
    cr = sin_frac((ar + 90) % 360);
    t  = dy * sr - dz * cr;
    xh = dx * cp + ((t * sp) >>> FRAC);
    yh = dy * cr + dz * sr;
    x = xh;
    y = -yh;
    z = 0;
    if (x != 0 || y != 0) begin
      // pre-rotate the left half plane by +-90 deg; -x axis lands on +180
      if (x < 0) begin
        ox = x;
        if (y >= 0) begin
          x = y;
          y = -ox;
          z = HALF_PI_Q30;
        end else begin
          x = -y;
          y = ox;
          z = -HALF_PI_Q30;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_q30[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_q30[i];
        end
      end
    end
    deg = (z * 18000 + longint'(bias_cdeg) * PI_Q30) / (100 * PI_Q30);
    h = (360 - deg) % 360;
    if (h < 0) h = h + 360;
    return HEAD_W'(h);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x      <= 16'sd419;
      off_y      <= 16'sd395;
      off_z      <= -16'sd169;
      bias_cdeg  <= 16'd21465;
      fail_count <= 0;
      pending    <= 0;
      heading_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HARD_IRON_X: off_x <= cfg_wdata;
          CFG_HARD_IRON_Y: off_y <= cfg_wdata;
          CFG_HARD_IRON_Z: off_z <= cfg_wdata;
          CFG_BIAS:        bias_cdeg <= cfg_wdata;
          default: ;
        endcase
      end
      if (push && !full)
        heading_q.push_back(heading_of(in_raw_x, in_raw_y, in_raw_z,
                                       in_pitch_deg, in_roll_deg));
      if (pop && !empty) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected heading word: expected none, actual %0d",
                   $time, out_heading_deg);
          fail_count <= fail_count + 1;
        end else begin
          logic [HEAD_W-1:0] want;
          want = heading_q.pop_front();
          if (out_heading_deg !== want) begin
            $display("%0t: heading_deg mismatch: expected %0d, actual %0d",
                     $time, want, out_heading_deg);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= heading_q.size();
    end
  end
endmodule

@@ tb/sv/tilt_compensated_compass_heading_top_tb.sv @@
// Testbench top for the compass heading block: stimulus, config phases and verdict.
module tilt_compensated_compass_heading_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcch_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] in_raw_x = '0;
  logic signed [15:0] in_raw_y = '0;
  logic signed [15:0] in_raw_z = '0;
  logic signed [7:0]  in_pitch_deg = '0;
  logic signed [7:0]  in_roll_deg = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [HEAD_W-1:0]  out_heading_deg;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_HARD_IRON_X;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;
  int phase = 0;           // 0: sender sparse, 1: receiver sparse, 2: no idling
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  localparam int DRAIN_CYCLES = 60;   // covers the whole pipeline plus queue slack

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tilt_compensated_compass_heading_top dut (.*);

  tcch_heading_checker chk (.*);

  // hard stop in case a handshake hangs
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: random pop; in the no-idle phase one long hold-off so the
  // pipe backs up and full rises while words keep being offered
  initial begin
    int phase2_cycles;
    bit held;
    phase2_cycles = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        phase2_cycles++;
        if (phase2_cycles == 30) begin
          pop = 1'b0;
          repeat (300) @(negedge clk);
          held = 1;
        end
      end
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input word, held until accepted; called at a falling edge
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [7:0] p,
                           logic signed [7:0] r);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    in_raw_x = x;
    in_raw_y = y;
    in_raw_z = z;
    in_pitch_deg = p;
    in_roll_deg = r;
    push = 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
    push = 1'b0;
  endtask

  // let every word come out, then give the pipe time to go quiet
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(logic [CFG_W-1:0] hx, logic [CFG_W-1:0] hy,
                         logic [CFG_W-1:0] hz, logic [CFG_W-1:0] b);
    drain();
    write_cfg(CFG_HARD_IRON_X, hx);
    write_cfg(CFG_HARD_IRON_Y, hy);
    write_cfg(CFG_HARD_IRON_Z, hz);
    write_cfg(CFG_BIAS, b);
  endtask

  // mostly real tilt range, sometimes any 8-bit angle
  function automatic logic signed [7:0] rand_tilt();
    if ($urandom_range(99) < 85) return 8'($signed($urandom_range(180)) - 90);
    return 8'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_axis();
    if ($urandom_range(99) < 20) return 16'($signed($urandom_range(400)) - 200);
    return 16'($urandom);
  endfunction

  task automatic random_words(int count);
    repeat (count)
      send_word(rand_axis(), rand_axis(), rand_axis(), rand_tilt(), rand_tilt());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset config: field extremes and tilt beyond +-90
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 8'sd90, 8'sd90);
    send_word(-16'sh8000, -16'sh8000, -16'sh8000, -8'sd90, -8'sd90);
    send_word(16'sh7fff, -16'sh8000, 16'sd0, 8'sh7f, -8'sh80);
    send_word(-16'sh8000, 16'sh7fff, 16'sh7fff, -8'sh80, 8'sh7f);
    send_word(16'sd1000, 16'sd0, 16'sd0, 8'sd0, 8'sd0);
    send_word(16'sd0, 16'sd1000, -16'sd500, 8'sd45, -8'sd30);
    send_word(16'sd419, 16'sd395, -16'sd169, 8'sd0, 8'sd0);  // zero vector
    send_word(16'sd419, 16'sd395, -16'sd169, 8'sd30, 8'sd60);

    // zero offsets and bias: zero vector, vectors on the negative x axis and on the y axis
    set_all(16'd0, 16'd0, 16'd0, 16'd0);
    send_word(16'sd0, 16'sd0, 16'sd0, 8'sd0, 8'sd0);
    send_word(-16'sd100, 16'sd0, 16'sd0, 8'sd0, 8'sd0);
    send_word(-16'sh8000, 16'sd0, 16'sd7, 8'sd0, 8'sd0);
    send_word(16'sd0, -16'sd1, 16'sd0, 8'sd0, 8'sd0);
    send_word(16'sd0, 16'sd1, 16'sd0, 8'sd0, 8'sd0);

    // bias past one turn, max unsigned
    set_all(16'd0, 16'd0, 16'd0, 16'hffff);
    send_word(-16'sd100, 16'sd0, 16'sd0, 8'sd0, 8'sd0);
    send_word(16'sd300, -16'sd300, 16'sd50, -8'sd10, 8'sd20);
    send_word(16'sd0, 16'sd0, 16'sd0, 8'sd0, 8'sd0);

    // sender sparse, receiver sparser
    set_all(16'h8000, 16'h7fff, 16'h8000, 16'd35999);
    phase = 0;
    send_idle_pct = 34;
    recv_idle_pct = 80;
    random_words(360);

    // the other way round
    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    phase = 1;
    send_idle_pct = 80;
    recv_idle_pct = 34;
    random_words(360);

    // no idling, random config, includes the long receiver hold-off
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(35999)));
    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(380);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ tilt_compensated_compass_heading_top.f @@
rtl/core/tcch_pkg.sv
rtl/core/tcch_queue.sv
rtl/core/tcch_front.sv
rtl/core/tcch_back.sv
rtl/core/tilt_compensated_compass_heading_top.sv
tb/sv/tcch_heading_checker.sv
tb/sv/tilt_compensated_compass_heading_top_tb.sv
